### rtl/gcdi_pkg.sv
package gcdi_pkg;

    localparam int FIELD_BITS = 64;
    localparam int WORD_BITS  = 64;
    localparam int SHIFT_BITS = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [SHIFT_BITS-1:0] shift_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ALIGN,
        ST_SUB,
        ST_FIX
    } gcdi_state_t;

    typedef struct packed {
        logic start;
        logic res_ready;
    } gcdi_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gcdi_status_t;

endpackage

### rtl/gcdi_core.sv
module gcdi_core
    import gcdi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  gcdi_ctrl_t   ctrl,
    input  word_t        x_value,
    input  word_t        y_modulus,
    output gcdi_status_t status,
    output word_t        gcd_result,
    output word_t        inverse_result
);

    gcdi_state_t state_reg, state_next;
    word_t       ra_reg, ra_next;
    word_t       rb_reg, rb_next;
    word_t       ca_reg, ca_next;
    word_t       cb_reg, cb_next;
    word_t       d_reg, d_next;
    word_t       y_reg, y_next;
    shift_t      shift_reg, shift_next;

    word_t d_dbl;
    word_t e_shift;
    word_t ra_sub;
    word_t ca_sub;
    logic  take;

    assign d_dbl   = {d_reg[WORD_BITS-2:0], 1'b0};
    assign e_shift = cb_reg << shift_reg;
    assign take    = (ra_reg >= d_reg);
    assign ra_sub  = take ? (ra_reg - d_reg) : ra_reg;
    assign ca_sub  = take ? (ca_reg - e_shift) : ca_reg;

    assign gcd_result     = ra_reg;
    assign inverse_result = ca_reg[WORD_BITS-1] ? (ca_reg + y_reg) : ca_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        d_reg     <= d_next;
        y_reg     <= y_next;
        shift_reg <= shift_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        d_next      = d_reg;
        y_next      = y_reg;
        shift_next  = shift_reg;
        status.busy = (state_reg != ST_IDLE);
        status.done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    y_next = y_modulus;
                    if (x_value > y_modulus)
                    begin
                        ra_next = x_value;
                        rb_next = y_modulus;
                        ca_next = word_t'(1);
                        cb_next = '0;
                    end
                    else
                    begin
                        ra_next = y_modulus;
                        rb_next = x_value;
                        ca_next = '0;
                        cb_next = word_t'(1);
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                d_next     = rb_reg;
                shift_next = '0;
                state_next = (rb_reg == '0) ? ST_FIX : ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (!d_reg[WORD_BITS-1] && (d_dbl <= ra_reg))
                begin
                    d_next     = d_dbl;
                    shift_next = shift_reg + shift_t'(1);
                end
                else
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (shift_reg == '0)
                begin
                    ra_next    = rb_reg;
                    rb_next    = ra_sub;
                    ca_next    = cb_reg;
                    cb_next    = ca_sub;
                    state_next = ST_CHECK;
                end
                else
                begin
                    ra_next    = ra_sub;
                    ca_next    = ca_sub;
                    d_next     = d_reg >> 1;
                    shift_next = shift_reg - shift_t'(1);
                end
            end
            ST_FIX:
            begin
                if (ctrl.res_ready)
                begin
                    status.done = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALIGN || state_reg == ST_SUB) |-> (rb_reg != '0))
        else $error("divisor is zero during a quotient step");

    a_aligned_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALIGN || state_reg == ST_SUB) |-> (d_reg == (rb_reg << shift_reg)))
        else $error("shifted divisor lost alignment with its shift count");

    a_remainder_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUB && shift_reg == '0) |=> (rb_reg < ra_reg))
        else $error("remainder is not below the divisor after a step");

    a_done_from_fix: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> (state_reg == ST_FIX && rb_reg == '0))
        else $error("result issued before the remainder reached zero");

endmodule

### rtl/gcd_and_modular_inverse_top.sv
// Channel  Dir  Beat contents (low bits first)
// s_axis   in   tdata[127:0] = x_value[63:0], y_modulus[63:0]
// m_axis   out  tdata[127:0] = gcd_result[63:0], inverse_result[63:0]
//
// One item at a time; each Euclid step makes a zero test, then the shared shift-subtract
// unit aligns the divisor and takes one quotient bit per subtract step, so the run time
// for 64-bit operands is set by the length of the remainder chain.
// The result sits in an output register, so a new beat is taken while it waits.
// rst_n clears the sequencer and the output valid flag asynchronously.
module gcd_and_modular_inverse_top
    import gcdi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [2*FIELD_BITS-1:0] s_axis_tdata,  // x_value, y_modulus
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [2*FIELD_BITS-1:0] m_axis_tdata   // gcd_result, inverse_result
);

    gcdi_ctrl_t   ctrl;
    gcdi_status_t status;
    word_t        gcd_w;
    word_t        inv_w;

    logic                    out_valid_reg, out_valid_next;
    logic [2*FIELD_BITS-1:0] out_data_reg, out_data_next;

    assign s_axis_tready  = !status.busy;
    assign ctrl.start     = s_axis_tvalid && !status.busy;
    assign ctrl.res_ready = !out_valid_reg || m_axis_tready;

    gcdi_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .x_value        (s_axis_tdata[WORD_BITS-1:0]),
        .y_modulus      (s_axis_tdata[FIELD_BITS+WORD_BITS-1:FIELD_BITS]),
        .status         (status),
        .gcd_result     (gcd_w),
        .inverse_result (inv_w)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {FIELD_BITS'(inv_w), FIELD_BITS'(gcd_w)};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### tb/gcd_inverse_monitor.sv
module gcd_inverse_monitor
    import gcdi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [2*FIELD_BITS-1:0] s_axis_tdata,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [2*FIELD_BITS-1:0] m_axis_tdata,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct packed {
        logic [FIELD_BITS-1:0] inverse_result;
        logic [FIELD_BITS-1:0] gcd_result;
    } gcd_pair_t;

    gcd_pair_t gcd_pair_q[$];

    function automatic gcd_pair_t euclid_gcd_inverse(input logic [FIELD_BITS-1:0] x_value,
                                                     input logic [FIELD_BITS-1:0] y_modulus);
        word_t     x;
        word_t     y;
        word_t     rem_hi;
        word_t     rem_lo;
        word_t     cof_hi;
        word_t     cof_lo;
        word_t     quot;
        word_t     tmp;
        gcd_pair_t res;
        x      = x_value[WORD_BITS-1:0];
        y      = y_modulus[WORD_BITS-1:0];
        rem_hi = y;
        rem_lo = x;
        cof_hi = '0;
        cof_lo = word_t'(1);
        if (rem_lo > rem_hi)
        begin
            tmp    = rem_hi;
            rem_hi = rem_lo;
            rem_lo = tmp;
            tmp    = cof_hi;
            cof_hi = cof_lo;
            cof_lo = tmp;
        end
        while (rem_lo != '0)
        begin
            quot   = rem_hi / rem_lo;
            tmp    = rem_hi - quot * rem_lo;
            rem_hi = rem_lo;
            rem_lo = tmp;
            tmp    = cof_hi - quot * cof_lo;
            cof_hi = cof_lo;
            cof_lo = tmp;
        end
        // A negative cofactor is brought into range by adding the modulus once.
        if (cof_hi[WORD_BITS-1])
            cof_hi = cof_hi + y;
        res.gcd_result     = FIELD_BITS'(rem_hi);
        res.inverse_result = FIELD_BITS'(cof_hi);
        return res;
    endfunction

    always @(posedge clk)
    begin
        gcd_pair_t want;
        gcd_pair_t got;
        if (!rst_n)
        begin
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                gcd_pair_q.push_back(euclid_gcd_inverse(s_axis_tdata[FIELD_BITS-1:0],
                                                        s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (gcd_pair_q.size() == 0)
                begin
                    $error("unexpected result beat: gcd_result %0h inverse_result %0h",
                           got.gcd_result, got.inverse_result);
                    mismatches++;
                end
                else
                begin
                    want = gcd_pair_q.pop_front();
                    if (got.gcd_result !== want.gcd_result)
                    begin
                        $error("gcd_result: expected %0h, actual %0h",
                               want.gcd_result, got.gcd_result);
                        mismatches++;
                    end
                    if (got.inverse_result !== want.inverse_result)
                    begin
                        $error("inverse_result: expected %0h, actual %0h",
                               want.inverse_result, got.inverse_result);
                        mismatches++;
                    end
                end
            end
            outstanding = gcd_pair_q.size();
        end
    end

endmodule

### tb/gcd_and_modular_inverse_top_tb.sv
module gcd_and_modular_inverse_top_tb;
    import gcdi_pkg::*;

    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam int          RANDOM_ITEMS = 450;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [2*FIELD_BITS-1:0] s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [2*FIELD_BITS-1:0] m_axis_tdata;
    int                      mismatches;
    int                      outstanding;
    bit                      quiet = 1'b0;
    int                      stall_left = 0;
    logic [63:0]             fib[0:93];

    always #10 clk = ~clk;

    gcd_and_modular_inverse_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gcd_inverse_monitor monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        else if (pick < 80)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_sized();
        return rand_word() >> $urandom_range(0, 63);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            stall_left    <= idle_length();
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_operands(input logic [63:0] x_value, input logic [63:0] y_modulus);
        int gap;
        gap = quiet ? 0 : idle_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y_modulus, x_value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random_operands();
        int          kind;
        int          k;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] g;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            a = rand_word();
            b = rand_word();
        end
        else if (kind < 45)
        begin
            // Mostly x below y with an odd modulus, the usual inverse request.
            b = rand_sized() | 64'd1;
            a = (b > 1) ? rand_word() % b : rand_sized();
        end
        else if (kind < 60)
        begin
            a = rand_sized();
            b = rand_sized();
        end
        else if (kind < 70)
        begin
            k = $urandom_range(1, 92);
            a = fib[k];
            b = fib[k+1];
            if ($urandom_range(0, 1))
            begin
                g = a;
                a = b;
                b = g;
            end
        end
        else if (kind < 82)
        begin
            g = (rand_word() >> $urandom_range(40, 63)) + 64'd1;
            a = g * (rand_word() >> $urandom_range(32, 63));
            b = g * (rand_word() >> $urandom_range(32, 63));
        end
        else if (kind < 92)
        begin
            a = 64'($urandom_range(0, 15));
            b = 64'($urandom_range(0, 15));
        end
        else
        begin
            a = rand_word();
            case ($urandom_range(0, 3))
                0: b = a;
                1: b = 64'd0;
                2:
                begin
                    b = a;
                    a = 64'd0;
                end
                default: b = ALL_ONES;
            endcase
        end
        send_operands(a, b);
    endtask

    initial
    begin
        fib[0] = 64'd0;
        fib[1] = 64'd1;
        for (int i = 2; i <= 93; i++)
            fib[i] = fib[i-1] + fib[i-2];

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_operands(64'd0, 64'd0);
        send_operands(64'd0, ALL_ONES);
        send_operands(ALL_ONES, 64'd0);
        send_operands(64'd1, 64'd0);
        send_operands(64'd0, 64'd1);
        send_operands(64'd5, 64'd5);
        send_operands(ALL_ONES, ALL_ONES);
        send_operands(64'd1, ALL_ONES);
        send_operands(ALL_ONES, 64'd1);
        send_operands(ALL_ONES - 64'd1, ALL_ONES);
        send_operands(64'd3, 64'd7);
        send_operands(64'd10, 64'd7);
        send_operands(64'd12, 64'd18);
        send_operands(64'd6, 64'd9);
        send_operands(fib[91], fib[92]);
        send_operands(fib[93], fib[92]);
        send_operands(64'h8000_0000_0000_0000, ALL_ONES);
        send_operands(64'd2, BIG_PRIME);
        send_operands(64'd123456789, BIG_PRIME);
        send_operands(BIG_PRIME - 64'd1, BIG_PRIME);
        send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // One stretch runs back to back with no idle cycles on either side.
            quiet = (n >= 200 && n < 260);
            send_random_operands();
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("gcd_and_modular_inverse_top test passed");
        else
            $display("gcd_and_modular_inverse_top test failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("gcd_and_modular_inverse_top test failed");
        $finish;
    end

endmodule
